### design/shared_credit_pool_per_task_core_assert.svh
// Assertion macros shared by the credit pool RTL.
// Bodies refer to clk and rst_n of the module that includes this header.
`ifndef SHARED_CREDIT_POOL_PER_TASK_CORE_ASSERT_SVH
`define SHARED_CREDIT_POOL_PER_TASK_CORE_ASSERT_SVH

// Same-cycle implication.
`define SCPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/scpt_pkg.sv
// Types and constants of the shared credit pool.
// No dependencies; used by scpt_slot_ram and the top level.
package scpt_pkg;

    localparam int CNT_W     = 32;
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    localparam logic [OP_W-1:0] OP_OPEN     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESERVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd3;
    localparam logic [OP_W-1:0] OP_TEARDOWN = 3'd4;

    localparam logic [ST_W-1:0] ST_APPLIED  = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [ST_W-1:0] ST_DEAD     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOCHANGE = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] gen;
        logic [CNT_W-1:0] cons;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       data;
    } ram_wr_t;

endpackage

### design/scpt_slot_ram.sv
// Per-task count table: one write port, one read port, registered read data.
// Depends on scpt_pkg.
module scpt_slot_ram
(
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [scpt_pkg::SLOT_W-1:0] rd_addr,
    output scpt_pkg::slot_entry_t       rd_data,
    input  scpt_pkg::ram_wr_t           wr
);

    scpt_pkg::slot_entry_t slot_mem [scpt_pkg::NUM_SLOTS];
    scpt_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/shared_credit_pool_per_task_core.sv
// Top level of the shared credit pool with per-task accounting.
// Depends on scpt_pkg, scpt_slot_ram and shared_credit_pool_per_task_core_assert.svh.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------------
//   command   start / busy         opcode, task_slot, amount
//   result    done (strobe)        granted, status, backpressured,
//                                  total_generated, total_consumed
//   config    cfg_valid/cfg_ready  cfg_data (credit_cap)
//
// A command holds busy high from the read state through the finish state: table read, two
// arithmetic steps on the 32-bit counts, write back. Then done pulses for one cycle, during
// which the next command may already start. The registered table read and the chain of
// 32-bit subtracts and compares account for these states.
// Reset clears the global counters, marks all slots dead and loads the cap with 16.
// The receiver cannot stall; a cap write waits while a command is starting or in flight.
`include "shared_credit_pool_per_task_core_assert.svh"

module shared_credit_pool_per_task_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [scpt_pkg::OP_W-1:0]   opcode,
    input  logic [scpt_pkg::SLOT_W-1:0] task_slot,
    input  logic [scpt_pkg::CNT_W-1:0]  amount,
    output logic                        done,
    output logic                        granted,
    output logic [scpt_pkg::ST_W-1:0]   status,
    output logic                        backpressured,
    output logic [scpt_pkg::CNT_W-1:0]  total_generated,
    output logic [scpt_pkg::CNT_W-1:0]  total_consumed,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scpt_pkg::CNT_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       done_reg;
    logic       accept;

    logic [scpt_pkg::NUM_SLOTS-1:0] alive_reg, alive_next;
    logic [scpt_pkg::CNT_W-1:0]     cap_reg;
    logic [scpt_pkg::CNT_W-1:0]     gg_reg, gg_next;
    logic [scpt_pkg::CNT_W-1:0]     gc_reg, gc_next;

    // command payload
    logic [scpt_pkg::OP_W-1:0]   op_reg;
    logic [scpt_pkg::SLOT_W-1:0] slot_reg;
    logic [scpt_pkg::CNT_W-1:0]  amt_reg;
    logic                        live_reg;

    // staged arithmetic
    logic [scpt_pkg::CNT_W-1:0] gen_reg, cons_reg, own_reg, clamp_reg, outst_reg;
    logic [scpt_pkg::CNT_W-1:0] rel_reg, inc_reg;
    logic                       inc_ok_reg, over_reg;

    // result registers
    logic                      granted_reg, granted_next;
    logic [scpt_pkg::ST_W-1:0] status_reg, status_next;
    logic                      bp_reg;

    scpt_pkg::slot_entry_t rd_data;
    scpt_pkg::ram_wr_t     wr_req;

    assign accept = start && (state_reg == S_IDLE);

    scpt_slot_ram u_slot_ram
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (task_slot),
        .rd_data (rd_data),
        .wr      (wr_req)
    );

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_READ : S_IDLE;
            S_READ:  state_next = S_CALC;
            S_CALC:  state_next = S_APPLY;
            S_APPLY: state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // apply the operation; counts wrap
    always_comb
    begin
        alive_next    = alive_reg;
        gg_next       = gg_reg;
        gc_next       = gc_reg;
        granted_next  = 1'b0;
        status_next   = scpt_pkg::ST_NOCHANGE;
        wr_req.en     = 1'b0;
        wr_req.addr   = slot_reg;
        wr_req.data   = '{gen: gen_reg, cons: cons_reg};
        if (state_reg == S_APPLY)
        begin
            case (op_reg)
                scpt_pkg::OP_OPEN:
                begin
                    if (!live_reg)
                    begin
                        alive_next[slot_reg] = 1'b1;
                        wr_req.en            = 1'b1;
                        wr_req.data          = '{gen: '0, cons: '0};
                        status_next          = scpt_pkg::ST_APPLIED;
                    end
                end
                scpt_pkg::OP_RESERVE:
                begin
                    if (!live_reg)
                    begin
                        granted_next = 1'b1;
                        status_next  = scpt_pkg::ST_DEAD;
                    end
                    else if (over_reg)
                    begin
                        status_next = scpt_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        gg_next         = gg_reg + amt_reg;
                        wr_req.en       = 1'b1;
                        wr_req.data.gen = gen_reg + amt_reg;
                        granted_next    = 1'b1;
                        status_next     = scpt_pkg::ST_APPLIED;
                    end
                end
                scpt_pkg::OP_RELEASE:
                begin
                    if (!live_reg)
                    begin
                        status_next = scpt_pkg::ST_DEAD;
                    end
                    else if (rel_reg != '0)
                    begin
                        gg_next         = gg_reg - rel_reg;
                        wr_req.en       = 1'b1;
                        wr_req.data.gen = gen_reg - rel_reg;
                        status_next     = scpt_pkg::ST_APPLIED;
                    end
                end
                scpt_pkg::OP_UPDATE:
                begin
                    if (!live_reg)
                    begin
                        status_next = scpt_pkg::ST_DEAD;
                    end
                    else if (inc_ok_reg)
                    begin
                        gc_next          = gc_reg + inc_reg;
                        wr_req.en        = 1'b1;
                        wr_req.data.cons = clamp_reg;
                        status_next      = scpt_pkg::ST_APPLIED;
                    end
                end
                scpt_pkg::OP_TEARDOWN:
                begin
                    if (!live_reg)
                    begin
                        status_next = scpt_pkg::ST_DEAD;
                    end
                    else
                    begin
                        // return whatever the slot still holds
                        alive_next[slot_reg] = 1'b0;
                        gg_next              = gg_reg - own_reg;
                        status_next          = scpt_pkg::ST_APPLIED;
                    end
                end
                default:
                begin
                    status_next = scpt_pkg::ST_NOCHANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            alive_reg <= '0;
            cap_reg   <= scpt_pkg::CAP_RESET;
            gg_reg    <= '0;
            gc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            alive_reg <= alive_next;
            gg_reg    <= gg_next;
            gc_reg    <= gc_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            slot_reg <= task_slot;
            amt_reg  <= amount;
            live_reg <= alive_reg[task_slot];
        end
        if (state_reg == S_READ)
        begin
            gen_reg   <= rd_data.gen;
            cons_reg  <= rd_data.cons;
            own_reg   <= rd_data.gen - rd_data.cons;
            clamp_reg <= (amt_reg < rd_data.gen) ? amt_reg : rd_data.gen;
            outst_reg <= gg_reg - gc_reg;
        end
        if (state_reg == S_CALC)
        begin
            rel_reg    <= (amt_reg < own_reg) ? amt_reg : own_reg;
            inc_reg    <= clamp_reg - cons_reg;
            inc_ok_reg <= clamp_reg > cons_reg;
            over_reg   <= outst_reg >= cap_reg;
        end
        if (state_reg == S_APPLY)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
        if (state_reg == S_FIN)
        begin
            bp_reg <= (gg_reg - gc_reg) >= cap_reg;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    // hold cap writes off while a command is starting or in flight
    assign cfg_ready       = !busy && !start;
    assign done            = done_reg;
    assign granted         = granted_reg;
    assign status          = status_reg;
    assign backpressured   = bp_reg;
    assign total_generated = gg_reg;
    assign total_consumed  = gc_reg;

    `SCPT_ASSERT_NXT(a_accept_reads, accept, state_reg == S_READ, "accept did not start a read")
    `SCPT_ASSERT_NXT(a_fin_done, state_reg == S_FIN, done && !busy, "no result after finish")
    `SCPT_ASSERT_IMP(a_wr_in_apply, wr_req.en, state_reg == S_APPLY, "table write outside apply")
    `SCPT_ASSERT_IMP(a_refused_not_granted, done && (status == scpt_pkg::ST_REFUSED), !granted,
        "refused reserve reported as granted")
    `SCPT_ASSERT_IMP(a_alive_in_apply, !$stable(alive_reg), $past(state_reg) == S_APPLY,
        "slot liveness changed outside apply")

endmodule

### tb/sv/tb_shared_credit_pool_per_task_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for shared_credit_pool_per_task_core: commands and cap writes
// are queued up front, a clocked driver plays them out and a clocked monitor checks
// every result against a cycle-free credit pool predictor. Depends on scpt_pkg and the core.

module tb_shared_credit_pool_per_task_core;
    import scpt_pkg::*;

    localparam int TAIL_ITEMS = 60;
    localparam int REPORT_MAX = 30;

    typedef enum logic [1:0] {ITEM_CMD, ITEM_CAP, ITEM_DRAIN} item_kind_t;

    typedef struct {
        item_kind_t        kind;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  value;
    } pool_item_t;

    typedef struct {
        logic             granted;
        logic [ST_W-1:0]  status;
        logic             backpressured;
        logic [CNT_W-1:0] generated;
        logic [CNT_W-1:0] consumed;
    } pool_result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     opcode        = '0;
    logic [SLOT_W-1:0]   task_slot     = '0;
    logic [CNT_W-1:0]    amount        = '0;
    logic                done;
    logic                granted;
    logic [ST_W-1:0]     status;
    logic                backpressured;
    logic [CNT_W-1:0]    total_generated;
    logic [CNT_W-1:0]    total_consumed;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_data      = '0;

    // Predictor copy of the pool
    logic [CNT_W-1:0]    cap_shadow    = CAP_RESET;
    logic [CNT_W-1:0]    pool_admitted = '0;
    logic [CNT_W-1:0]    pool_consumed = '0;
    logic                slot_live     [NUM_SLOTS] = '{default: 1'b0};
    logic [CNT_W-1:0]    slot_admitted [NUM_SLOTS] = '{default: '0};
    logic [CNT_W-1:0]    slot_consumed [NUM_SLOTS] = '{default: '0};

    pool_item_t          item_q[$];
    pool_result_t        pending_results[int];
    int                  n_accepted    = 0;
    int                  n_results     = 0;
    int                  n_cap_writes  = 0;
    int                  mismatches    = 0;
    int                  status_seen   [4] = '{default: 0};
    int                  idle_left     = 0;
    logic                calm          = 1'b0;

    shared_credit_pool_per_task_core u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .task_slot       (task_slot),
        .amount          (amount),
        .done            (done),
        .granted         (granted),
        .status          (status),
        .backpressured   (backpressured),
        .total_generated (total_generated),
        .total_consumed  (total_consumed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // Apply one command to the shadow pool and return the result it must produce.
    function automatic pool_result_t predict_credit_op(logic [OP_W-1:0] op,
                                                       logic [SLOT_W-1:0] slot,
                                                       logic [CNT_W-1:0] amt);
        pool_result_t     res;
        logic [CNT_W-1:0] backlog;
        logic [CNT_W-1:0] owned;
        logic [CNT_W-1:0] clamped;
        logic             live;
        live        = slot_live[slot];
        res.granted = 1'b0;
        res.status  = ST_NOCHANGE;
        backlog     = pool_admitted - pool_consumed;
        owned       = slot_admitted[slot] - slot_consumed[slot];
        case (op)
            OP_OPEN:
            begin
                if (!live)
                begin
                    slot_live[slot]     = 1'b1;
                    slot_admitted[slot] = '0;
                    slot_consumed[slot] = '0;
                    res.status          = ST_APPLIED;
                end
            end
            OP_RESERVE:
            begin
                if (!live)
                begin
                    res.granted = 1'b1;
                    res.status  = ST_DEAD;
                end
                else if (backlog >= cap_shadow)
                begin
                    res.status = ST_REFUSED;
                end
                else
                begin
                    // whole group goes in, even past the cap
                    pool_admitted       = pool_admitted + amt;
                    slot_admitted[slot] = slot_admitted[slot] + amt;
                    res.granted         = 1'b1;
                    res.status          = ST_APPLIED;
                end
            end
            OP_RELEASE:
            begin
                if (!live)
                begin
                    res.status = ST_DEAD;
                end
                else
                begin
                    clamped = (amt < owned) ? amt : owned;
                    if (clamped != '0)
                    begin
                        slot_admitted[slot] = slot_admitted[slot] - clamped;
                        pool_admitted       = pool_admitted - clamped;
                        res.status          = ST_APPLIED;
                    end
                end
            end
            OP_UPDATE:
            begin
                if (!live)
                begin
                    res.status = ST_DEAD;
                end
                else
                begin
                    // cumulative total, clamped to what the slot was admitted
                    clamped = (amt < slot_admitted[slot]) ? amt : slot_admitted[slot];
                    if (clamped > slot_consumed[slot])
                    begin
                        pool_consumed       = pool_consumed + (clamped - slot_consumed[slot]);
                        slot_consumed[slot] = clamped;
                        res.status          = ST_APPLIED;
                    end
                end
            end
            OP_TEARDOWN:
            begin
                if (!live)
                begin
                    res.status = ST_DEAD;
                end
                else
                begin
                    slot_live[slot] = 1'b0;
                    pool_admitted   = pool_admitted - owned;
                    res.status      = ST_APPLIED;
                end
            end
            default:
            begin
            end
        endcase
        backlog           = pool_admitted - pool_consumed;
        res.backpressured = (backlog >= cap_shadow);
        res.generated     = pool_admitted;
        res.consumed      = pool_consumed;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_MAX)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_cmd(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic [CNT_W-1:0] amt);
        pool_item_t item;
        item.kind  = ITEM_CMD;
        item.op    = op;
        item.slot  = slot;
        item.value = amt;
        item_q.push_back(item);
    endtask

    // Write the cap only once the pool has gone quiet.
    task automatic push_cap(logic [CNT_W-1:0] cap);
        pool_item_t item;
        item.kind  = ITEM_DRAIN;
        item.op    = '0;
        item.slot  = '0;
        item.value = '0;
        item_q.push_back(item);
        item.kind  = ITEM_CAP;
        item.value = cap;
        item_q.push_back(item);
    endtask

    // Driver: commands and cap writes from item_q, with random idle bursts.
    always @(posedge clk)
    begin
        pool_item_t item;
        logic       cmd_taken;
        logic       next_start;
        logic       next_cfg;
        if (rst_n)
        begin
            cmd_taken = start && !busy;
            if (cmd_taken)
            begin
                pending_results[n_accepted] = predict_credit_op(opcode, task_slot, amount);
                n_accepted <= n_accepted + 1;
                if ($urandom_range(0, 29) == 0)
                    calm = !calm;
                if (!calm && item_q.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 12);
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_shadow = cfg_data;
                n_cap_writes <= n_cap_writes + 1;
            end
            // hold a transfer that is still waiting for its handshake
            if (!(start && !cmd_taken) && !(cfg_valid && !cfg_ready))
            begin
                next_start = 1'b0;
                next_cfg   = 1'b0;
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (item_q.size() > 0)
                begin
                    item = item_q[0];
                    case (item.kind)
                        ITEM_CMD:
                        begin
                            void'(item_q.pop_front());
                            opcode     <= item.op;
                            task_slot  <= item.slot;
                            amount     <= item.value;
                            next_start = 1'b1;
                        end
                        ITEM_CAP:
                        begin
                            void'(item_q.pop_front());
                            cfg_data <= item.value;
                            next_cfg = 1'b1;
                        end
                        default:
                        begin
                            if (!cmd_taken && n_results == n_accepted)
                                void'(item_q.pop_front());
                        end
                    endcase
                end
                start     <= next_start;
                cfg_valid <= next_cfg;
            end
        end
    end

    // Monitor: match each done strobe against the oldest pending result.
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && done)
        begin
            if (n_results >= n_accepted)
            begin
                report_mismatch($sformatf("result with no command pending (status %0d)",
                                          status));
            end
            else
            begin
                want = pending_results[n_results];
                pending_results.delete(n_results);
                if (granted !== want.granted)
                    report_mismatch($sformatf("#%0d granted got %b expected %b",
                                              n_results, granted, want.granted));
                if (status !== want.status)
                    report_mismatch($sformatf("#%0d status got %0d expected %0d",
                                              n_results, status, want.status));
                if (backpressured !== want.backpressured)
                    report_mismatch($sformatf("#%0d backpressured got %b expected %b",
                                              n_results, backpressured, want.backpressured));
                if (total_generated !== want.generated)
                    report_mismatch($sformatf("#%0d total_generated got %h expected %h",
                                              n_results, total_generated, want.generated));
                if (total_consumed !== want.consumed)
                    report_mismatch($sformatf("#%0d total_consumed got %h expected %h",
                                              n_results, total_consumed, want.consumed));
                status_seen[want.status]++;
                n_results <= n_results + 1;
            end
        end
    end

    initial
    begin
        logic              gen_open  [NUM_SLOTS];
        logic [CNT_W-1:0]  gen_total [NUM_SLOTS];
        logic [SLOT_W-1:0] s;
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  amt;
        logic [CNT_W-1:0]  cap;
        int                n_random;
        int                n_phase;
        int                phase_len;
        int                pick;
        int                k;

        // Directed: dead slots, open twice, overshoot, refusal, clamps, releases.
        push_cmd(OP_RESERVE, 4'd3, 32'd5);
        push_cmd(OP_RELEASE, 4'd3, 32'd5);
        push_cmd(OP_UPDATE, 4'd3, 32'd5);
        push_cmd(OP_TEARDOWN, 4'd3, 32'd0);
        push_cmd(OP_OPEN, 4'd0, 32'd0);
        push_cmd(OP_OPEN, 4'd0, 32'd0);
        push_cmd(OP_RESERVE, 4'd0, 32'd0);
        push_cmd(OP_RESERVE, 4'd0, 32'd20);
        push_cmd(OP_RESERVE, 4'd0, 32'd1);
        push_cmd(OP_UPDATE, 4'd0, 32'hFFFF_FFFF);
        push_cmd(OP_UPDATE, 4'd0, 32'd5);
        push_cmd(OP_RELEASE, 4'd0, 32'd0);
        push_cmd(OP_RESERVE, 4'd0, 32'd10);
        push_cmd(OP_RELEASE, 4'd0, 32'd3);
        push_cmd(OP_RELEASE, 4'd0, 32'hFFFF_FFFF);
        push_cmd(OP_RELEASE, 4'd0, 32'd1);
        push_cmd(OP_OPEN, 4'd15, 32'd0);
        push_cmd(OP_RESERVE, 4'd15, 32'd4);
        push_cmd(OP_TEARDOWN, 4'd15, 32'd0);
        push_cmd(OP_OPEN, 4'd14, 32'd0);
        push_cmd(OP_TEARDOWN, 4'd14, 32'd0);
        push_cmd(3'd5, 4'd0, 32'd7);
        push_cmd(3'd7, 4'd0, 32'd7);
        // widest cap: wrap the global counters
        push_cap(32'hFFFF_FFFF);
        push_cmd(OP_RESERVE, 4'd0, 32'h8000_0000);
        push_cmd(OP_RESERVE, 4'd0, 32'h8000_0000);
        push_cmd(OP_RESERVE, 4'd0, 32'hFFFF_FFFF);
        // zero cap: every live reserve refused
        push_cap(32'd0);
        push_cmd(OP_RESERVE, 4'd0, 32'd1);
        push_cmd(OP_TEARDOWN, 4'd0, 32'd0);

        // Random phases: mostly open / reserve / update / release / teardown sessions.
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            gen_open[k]  = 1'b0;
            gen_total[k] = '0;
        end
        gen_open[1] = 1'b0;
        n_random    = 0;
        n_phase     = 0;
        while (n_random < 400)
        begin
            case ($urandom_range(0, 6))
                0: cap = 32'd1;
                1: cap = $urandom_range(2, 12);
                2: cap = $urandom_range(13, 64);
                3: cap = $urandom;
                4: cap = 32'hFFFF_FFFF;
                5: cap = CAP_RESET;
                default: cap = 32'd0;
            endcase
            if (n_phase == 0)
                cap = 32'd1;
            push_cap(cap);
            phase_len = $urandom_range(40, 90);
            for (k = 0; k < phase_len; k++)
            begin
                pick = $urandom_range(0, 99);
                s    = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                amt  = $urandom;
                if (pick < 8)
                begin
                    op = OP_W'($urandom_range(0, 7));
                end
                else if (!gen_open[s] && pick < 80)
                begin
                    op = OP_OPEN;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 38)
                    begin
                        op = OP_RESERVE;
                        if ($urandom_range(0, 19) != 0)
                            amt = $urandom_range(0, 6);
                    end
                    else if (pick < 68)
                    begin
                        op           = OP_UPDATE;
                        gen_total[s] = gen_total[s] + $urandom_range(0, 5);
                        if ($urandom_range(0, 9) != 0)
                            amt = gen_total[s];
                    end
                    else if (pick < 84)
                    begin
                        op  = OP_RELEASE;
                        amt = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                          : 32'($urandom_range(0, 4));
                    end
                    else if (pick < 93)
                    begin
                        op = OP_TEARDOWN;
                    end
                    else if (pick < 97)
                    begin
                        op = OP_OPEN;
                    end
                    else
                    begin
                        op = OP_W'($urandom_range(5, 7));
                    end
                end
                if (op == OP_OPEN && !gen_open[s])
                begin
                    gen_open[s]  = 1'b1;
                    gen_total[s] = '0;
                end
                if (op == OP_TEARDOWN)
                    gen_open[s] = 1'b0;
                push_cmd(op, s, amt);
            end
            n_random += phase_len;
            n_phase++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (item_q.size() != 0 || start || cfg_valid || n_results != n_accepted);
        repeat (20) @(negedge clk);

        $display("Ran %0d commands under %0d cap writes, cap 0, 1 and all ones among them.",
                 n_accepted, n_cap_writes);
        $display("Outcomes: %0d applied, %0d refused over cap, %0d dead slot, %0d no change.",
                 status_seen[ST_APPLIED], status_seen[ST_REFUSED],
                 status_seen[ST_DEAD], status_seen[ST_NOCHANGE]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timeout: %0d commands accepted, %0d results seen", n_accepted, n_results);
        $display("Regression FAIL");
        $finish;
    end

endmodule
